// ===== rtl/core/tcpd_pkg.sv =====
// Package for the two-class priority deque: request kinds, status codes,
// payload widths and the controller-to-datapath command struct.
// No dependencies.
package tcpd_pkg;

    localparam int KIND_W   = 3;
    localparam int OID_W    = 16;
    localparam int REF_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT     = 3'd0,
        KIND_POP_FRONT  = 3'd1,
        KIND_POP_BACK   = 3'd2,
        KIND_PEEK_FRONT = 3'd3,
        KIND_PEEK_BACK  = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_DUP   = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        CTRL_IDLE  = 1'b0,
        CTRL_APPLY = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic apply;
    } ctrl_cmd_t;

endpackage

// ===== rtl/core/tcpd_ctrl.sv =====
// Controller for the two-class priority deque: request sequencing and the
// output register handshake. Depends on tcpd_pkg.
module tcpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tcpd_pkg::ctrl_cmd_t cmd
);

    tcpd_pkg::ctrl_state_t state_reg;
    tcpd_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcpd_pkg::CTRL_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = tcpd_pkg::CTRL_APPLY;
                end
            end
            tcpd_pkg::CTRL_APPLY:
            begin
                if (out_free)
                begin
                    state_next = tcpd_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = tcpd_pkg::CTRL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.apply   = 1'b0;
        unique case (state_reg)
            tcpd_pkg::CTRL_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            tcpd_pkg::CTRL_APPLY:
            begin
                cmd.apply = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcpd_pkg::CTRL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/tcpd_datapath.sv =====
// Datapath for the two-class priority deque: the row of entry cells, the
// parallel duplicate check, the counters and the result register.
// Depends on tcpd_pkg.
module tcpd_datapath #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcpd_pkg::ctrl_cmd_t           cmd,
    input  logic [tcpd_pkg::KIND_W-1:0]   kind,
    input  logic [tcpd_pkg::OID_W-1:0]    order_id,
    input  logic [tcpd_pkg::REF_W-1:0]    customer_ref,
    input  logic                          vip,
    output logic [tcpd_pkg::STATUS_W-1:0] status,
    output logic [tcpd_pkg::OID_W-1:0]    out_id,
    output logic [tcpd_pkg::REF_W-1:0]    out_customer,
    output logic                          out_vip,
    output logic [tcpd_pkg::OCC_W-1:0]    occupancy
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ID_BITS-1:0]         id_reg   [DEPTH];
    logic [tcpd_pkg::REF_W-1:0] cust_reg [DEPTH];
    logic                       pri_reg  [DEPTH];
    logic [ID_BITS-1:0]         id_next  [DEPTH];
    logic [tcpd_pkg::REF_W-1:0] cust_next[DEPTH];
    logic                       pri_next [DEPTH];
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [CNT_W-1:0]           prio_reg;
    logic [CNT_W-1:0]           prio_next;

    logic [tcpd_pkg::KIND_W-1:0] req_kind_reg;
    logic [ID_BITS-1:0]          req_id_reg;
    logic [tcpd_pkg::REF_W-1:0]  req_cust_reg;
    logic                        req_vip_reg;
    logic                        dup_reg;
    logic [ID_BITS-1:0]          front_id_reg;
    logic [tcpd_pkg::REF_W-1:0]  front_cust_reg;
    logic                        front_pri_reg;
    logic [ID_BITS-1:0]          back_id_reg;
    logic [tcpd_pkg::REF_W-1:0]  back_cust_reg;
    logic                        back_pri_reg;

    logic [tcpd_pkg::STATUS_W-1:0] res_status_reg;
    logic [tcpd_pkg::OID_W-1:0]    res_id_reg;
    logic [tcpd_pkg::REF_W-1:0]    res_cust_reg;
    logic                          res_vip_reg;
    logic [tcpd_pkg::OCC_W-1:0]    res_occ_reg;
    tcpd_pkg::status_t             res_status_next;
    logic [ID_BITS-1:0]            res_id_sel;
    logic [tcpd_pkg::REF_W-1:0]    res_cust_next;
    logic                          res_vip_next;

    logic [ID_BITS-1:0] in_id;
    logic [DEPTH-1:0]   hit;
    logic [IDX_W-1:0]   back_idx;
    logic [CNT_W-1:0]   ins_pos;
    logic               is_empty;
    logic               is_full;
    logic [31:0]        count_wide;
    logic [31:0]        id_wide;

    assign in_id    = ID_BITS'(32'(order_id));
    assign back_idx = IDX_W'(count_reg - CNT_W'(1));
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign ins_pos  = req_vip_reg ? prio_reg : count_reg;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit[i] = (CNT_W'(i) < count_reg) && (id_reg[i] == in_id);
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            id_next[i]   = id_reg[i];
            cust_next[i] = cust_reg[i];
            pri_next[i]  = pri_reg[i];
        end
        count_next      = count_reg;
        prio_next       = prio_reg;
        res_status_next = tcpd_pkg::ST_OK;
        res_id_sel      = '0;
        res_cust_next   = '0;
        res_vip_next    = 1'b0;
        unique case (req_kind_reg)
            tcpd_pkg::KIND_INSERT:
            begin
                if (dup_reg)
                begin
                    res_status_next = tcpd_pkg::ST_DUP;
                end
                else if (is_full)
                begin
                    res_status_next = tcpd_pkg::ST_FULL;
                end
                else
                begin
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        if (CNT_W'(i) > ins_pos)
                        begin
                            id_next[i]   = id_reg[i-1];
                            cust_next[i] = cust_reg[i-1];
                            pri_next[i]  = pri_reg[i-1];
                        end
                    end
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (CNT_W'(i) == ins_pos)
                        begin
                            id_next[i]   = req_id_reg;
                            cust_next[i] = req_cust_reg;
                            pri_next[i]  = req_vip_reg;
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                    if (req_vip_reg)
                    begin
                        prio_next = prio_reg + CNT_W'(1);
                    end
                end
            end
            tcpd_pkg::KIND_POP_FRONT, tcpd_pkg::KIND_PEEK_FRONT:
            begin
                if (is_empty)
                begin
                    res_status_next = tcpd_pkg::ST_EMPTY;
                end
                else
                begin
                    res_id_sel    = front_id_reg;
                    res_cust_next = front_cust_reg;
                    res_vip_next  = front_pri_reg;
                    if (req_kind_reg == tcpd_pkg::KIND_POP_FRONT)
                    begin
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            id_next[i]   = id_reg[i+1];
                            cust_next[i] = cust_reg[i+1];
                            pri_next[i]  = pri_reg[i+1];
                        end
                        count_next = count_reg - CNT_W'(1);
                        if (front_pri_reg && (prio_reg != '0))
                        begin
                            prio_next = prio_reg - CNT_W'(1);
                        end
                    end
                end
            end
            tcpd_pkg::KIND_POP_BACK, tcpd_pkg::KIND_PEEK_BACK:
            begin
                if (is_empty)
                begin
                    res_status_next = tcpd_pkg::ST_EMPTY;
                end
                else
                begin
                    res_id_sel    = back_id_reg;
                    res_cust_next = back_cust_reg;
                    res_vip_next  = back_pri_reg;
                    if (req_kind_reg == tcpd_pkg::KIND_POP_BACK)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        if (back_pri_reg && (prio_reg != '0))
                        begin
                            prio_next = prio_reg - CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                res_status_next = tcpd_pkg::ST_OK;
            end
        endcase
    end

    assign count_wide = 32'(count_next);
    assign id_wide    = 32'(res_id_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            prio_reg  <= '0;
        end
        else if (cmd.apply)
        begin
            count_reg <= count_next;
            prio_reg  <= prio_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                id_reg[i]   <= id_next[i];
                cust_reg[i] <= cust_next[i];
                pri_reg[i]  <= pri_next[i];
            end
            res_status_reg <= res_status_next;
            res_id_reg     <= id_wide[tcpd_pkg::OID_W-1:0];
            res_cust_reg   <= res_cust_next;
            res_vip_reg    <= res_vip_next;
            res_occ_reg    <= count_wide[tcpd_pkg::OCC_W-1:0];
        end
        if (cmd.capture)
        begin
            req_kind_reg   <= kind;
            req_id_reg     <= in_id;
            req_cust_reg   <= customer_ref;
            req_vip_reg    <= vip;
            dup_reg        <= |hit;
            front_id_reg   <= id_reg[0];
            front_cust_reg <= cust_reg[0];
            front_pri_reg  <= pri_reg[0];
            back_id_reg    <= id_reg[back_idx];
            back_cust_reg  <= cust_reg[back_idx];
            back_pri_reg   <= pri_reg[back_idx];
        end
    end

    assign status       = res_status_reg;
    assign out_id       = res_id_reg;
    assign out_customer = res_cust_reg;
    assign out_vip      = res_vip_reg;
    assign occupancy    = res_occ_reg;

endmodule

// ===== rtl/core/two_class_priority_deque_top.sv =====
// Top level of the two-class priority deque: stream ports, controller and
// datapath. Depends on tcpd_pkg, tcpd_ctrl and tcpd_datapath.
//
// The block holds up to DEPTH entries, with priority entries kept as a
// prefix. A request is accepted in the idle state: every cell compares its
// id against the incoming one in parallel and the front and back entries are
// read. In the apply state, once the output register is free, the cells shift
// in place and the result is loaded into the output register. A new request
// is accepted while a result waits, but the following result is held until
// that one is taken. Every request gives exactly one result transaction.
module two_class_priority_deque_top #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // kind[2:0], order_id[18:3], customer_ref[34:19], zero pad[39:35]
    input  logic [tcpd_pkg::S_DATA_W-1:0] s_tdata,
    // vip[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], out_id[17:2], out_customer[33:18], occupancy[38:34], pad[39]
    output logic [tcpd_pkg::M_DATA_W-1:0] m_tdata,
    // out_vip[0]
    output logic                          m_tuser
);

    tcpd_pkg::ctrl_cmd_t           cmd;
    logic [tcpd_pkg::STATUS_W-1:0] status;
    logic [tcpd_pkg::OID_W-1:0]    out_id;
    logic [tcpd_pkg::REF_W-1:0]    out_customer;
    logic [tcpd_pkg::OCC_W-1:0]    occupancy;

    tcpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tcpd_datapath #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (s_tdata[2:0]),
        .order_id     (s_tdata[18:3]),
        .customer_ref (s_tdata[34:19]),
        .vip          (s_tuser),
        .status       (status),
        .out_id       (out_id),
        .out_customer (out_customer),
        .out_vip      (m_tuser),
        .occupancy    (occupancy)
    );

    assign m_tdata = {1'b0, occupancy, out_customer, out_id, status};

endmodule
